@@ sv/fstt_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes for the fixed-step timer table.
// No dependencies.
package fstt_pkg;
  localparam logic [1:0] OP_ADVANCE = 2'd0;
  localparam logic [1:0] OP_ADD_ONE = 2'd1;
  localparam logic [1:0] OP_ADD_PER = 2'd2;
  localparam logic [1:0] OP_CANCEL  = 2'd3;

  localparam logic [2:0] K_ADDED  = 3'd0;
  localparam logic [2:0] K_FULL   = 3'd1;
  localparam logic [2:0] K_CANCEL = 3'd2;
  localparam logic [2:0] K_FIRED  = 3'd3;
  localparam logic [2:0] K_PASS   = 3'd4;
  localparam logic [2:0] K_NOPASS = 3'd5;

  localparam int REM_W = 34;
  localparam int LAG_W = 40;

  typedef logic signed [REM_W-1:0] rem_t;

  // One slot entry as stored in memory.
  typedef struct packed {
    logic        periodic;
    rem_t        remaining;
    logic [31:0] period;
  } slot_ent_t;
endpackage

@@ sv/fstt_slot_mem.sv @@
`timescale 1ns / 1ps
// Slot entry memory: one write port, one registered read port.
// Depends on fstt_pkg.
module fstt_slot_mem
  import fstt_pkg::*;
#(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  slot_ent_t       wdata,
  input  logic [AW-1:0]   raddr,
  output slot_ent_t       rdata
);
  slot_ent_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ sv/fixed_step_timer_table_top.sv @@
`timescale 1ns / 1ps
// Fixed-step timer table: SLOTS one-shot/periodic timers driven by a lag accumulator.
// Uses fstt_pkg and fstt_slot_mem.
//
// Usage: pulse start with the item while busy is low. Adds take the lowest free
// slot and return a handle (kind added) or table full. Cancel frees all slots
// holding the handle. Advance adds elapsed time to the lag and runs up to
// MAX_PASSES passes of one tick each; each pass lists fired timers (one-shots
// first, then periodic, each by ascending handle, ties by slot) and ends with a
// pass-done result. An advance that runs no pass answers no-pass.
// Results appear for one cycle with out_valid; out_last marks the final one. The
// receiver cannot stall, so results are never held.
// Timing: add and cancel answer in the cycle after the transaction and never raise
// busy. An advance runs a closing step plus, per pass, a decrement of all entries
// through the memory, two empty scans (one per group) and a pass-done step; each
// fired timer adds a scan over the handle table and a read-modify-write step
// (written back only for periodic timers).
// The memory read port sets the pace: one entry per cycle.
// Reset clears valid bits, lag and handle counter; tick_length returns to 16.
// cfg_ready is high while idle.
module fixed_step_timer_table_top
  import fstt_pkg::*;
#(
  parameter int SLOTS       = 8,
  parameter int MAX_PASSES  = 3,
  parameter int HANDLE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_elapsed_time,
  input  logic [31:0] in_delay,
  input  logic [15:0] in_cancel_handle,
  output logic        out_valid,
  output logic [2:0]  out_kind,
  output logic [15:0] out_handle,
  output logic [31:0] out_overshoot,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);
  localparam int AW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW  = $clog2(SLOTS + 1);
  localparam int PW  = $clog2(MAX_PASSES + 1);
  localparam int HB  = HANDLE_BITS;
  localparam logic [LAG_W-1:0] LAG_MAX = '1;
  localparam rem_t REM_MAX = {1'b0, {(REM_W-1){1'b1}}};
  localparam rem_t REM_MIN = {1'b1, {(REM_W-1){1'b0}}};

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ADV   = 4'd1;
  localparam logic [3:0] S_DEC   = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_FRD   = 4'd4;
  localparam logic [3:0] S_FWR   = 4'd5;
  localparam logic [3:0] S_PEND  = 4'd6;

  logic [3:0]        state_r;
  logic [31:0]       tick_r;
  logic [LAG_W-1:0]  lag_r;
  logic [HB-1:0]     next_h_r;
  logic [SLOTS-1:0]  valid_r;
  logic [SLOTS-1:0]  pend_r;        // expired and not yet reported this pass
  logic [SLOTS-1:0]  pper_r;        // periodic flag copy for ordering
  logic [HB-1:0]     hnd_r [SLOTS]; // handles, read at a scan index each cycle
  logic              grp_r;         // 0 one-shot group, 1 periodic group
  logic [PW-1:0]     passes_r;
  logic [CW-1:0]     idx_r;
  logic [AW-1:0]     best_r;
  logic              found_r;
  logic [31:0]       tick_use_r;

  // memory
  logic      we;
  logic [AW-1:0] waddr, raddr;
  slot_ent_t wdata, rdata;

  fstt_slot_mem #(.DEPTH(SLOTS), .AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = !busy;

  // lowest free slot
  logic          has_free;
  logic [AW-1:0] free_idx;
  always_comb begin
    has_free = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        has_free = 1'b1;
        free_idx = AW'(i);
      end
    end
  end

  logic [HB-1:0] h_inc;
  assign h_inc = (next_h_r + HB'(1) == '0) ? HB'(1) : next_h_r + HB'(1);

  logic [LAG_W:0] lag_sum;
  assign lag_sum = {1'b0, lag_r} + {{(LAG_W-31){1'b0}}, in_elapsed_time};

  // decrement pipeline: idx_r addresses read, idx_r-1 is written
  logic [AW-1:0] widx;
  assign widx = AW'(idx_r - CW'(1));
  logic signed [REM_W:0] dec_v, add_v;
  assign dec_v = {rdata.remaining[REM_W-1], rdata.remaining}
               - $signed({3'b000, tick_use_r});
  assign add_v = {rdata.remaining[REM_W-1], rdata.remaining}
               + $signed({3'b000, rdata.period});
  rem_t dec_sat, add_sat;
  assign dec_sat = (dec_v < $signed({REM_MIN[REM_W-1], REM_MIN})) ? REM_MIN
                 : rem_t'(dec_v);
  assign add_sat = (add_v > $signed({1'b0, REM_MAX})) ? REM_MAX : rem_t'(add_v);

  logic [REM_W-1:0] neg_rem;
  assign neg_rem = -rdata.remaining;
  logic [31:0] over_sat;
  assign over_sat = (neg_rem[REM_W-1:32] != '0) ? 32'hFFFF_FFFF : neg_rem[31:0];

  logic [AW-1:0] sidx;
  assign sidx = idx_r[AW-1:0];
  logic cand;
  assign cand = pend_r[sidx] && (pper_r[sidx] == grp_r);

  always_comb begin
    we    = 1'b0;
    waddr = widx;
    wdata = rdata;
    raddr = sidx;
    case (state_r)
      S_IDLE: begin
        waddr = free_idx;
        wdata.periodic  = (in_op == OP_ADD_PER);
        wdata.remaining = rem_t'({2'b00, in_delay});
        wdata.period    = in_delay;
        we = start && (in_op == OP_ADD_ONE || in_op == OP_ADD_PER) && has_free;
      end
      S_DEC: begin
        wdata.remaining = dec_sat;
        we = (idx_r != '0) && valid_r[widx];
      end
      S_FRD: raddr = best_r;
      S_FWR: begin
        waddr = best_r;
        wdata.remaining = add_sat;
        we = grp_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      tick_r    <= 32'd16;
      lag_r     <= '0;
      next_h_r  <= '0;
      valid_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (cfg_valid) tick_r <= cfg_data;
          if (start) begin
            out_kind      <= K_CANCEL;
            out_handle    <= '0;
            out_overshoot <= '0;
            out_last      <= 1'b1;
            case (in_op)
              OP_ADVANCE: begin
                lag_r      <= lag_sum[LAG_W] ? LAG_MAX : lag_sum[LAG_W-1:0];
                tick_use_r <= (tick_r == '0) ? 32'd1 : tick_r;
                passes_r   <= '0;
                state_r    <= S_ADV;
              end
              OP_CANCEL: begin
                out_valid <= 1'b1;
                for (int i = 0; i < SLOTS; i++)
                  if (32'(hnd_r[i]) == 32'(in_cancel_handle))
                    valid_r[i] <= 1'b0;
              end
              default: begin
                out_valid <= 1'b1;
                if (has_free) begin
                  next_h_r         <= h_inc;
                  valid_r[free_idx] <= 1'b1;
                  hnd_r[free_idx]  <= h_inc;
                  pper_r[free_idx] <= (in_op == OP_ADD_PER);
                  out_kind         <= K_ADDED;
                  out_handle       <= 16'(h_inc);
                end else begin
                  out_kind <= K_FULL;
                end
              end
            endcase
          end
        end
        S_ADV: begin
          if (passes_r < PW'(MAX_PASSES) && lag_r >= {8'd0, tick_use_r}) begin
            lag_r   <= lag_r - {8'd0, tick_use_r};
            idx_r   <= '0;
            pend_r  <= '0;
            state_r <= S_DEC;
          end else begin
            if (passes_r == '0) begin
              out_valid     <= 1'b1;
              out_kind      <= K_NOPASS;
              out_handle    <= '0;
              out_overshoot <= '0;
              out_last      <= 1'b1;
            end
            state_r <= S_IDLE;
          end
        end
        S_DEC: begin
          if (idx_r != '0 && valid_r[widx] && dec_sat <= 0) pend_r[widx] <= 1'b1;
          if (idx_r == CW'(SLOTS)) begin
            idx_r   <= '0;
            grp_r   <= 1'b0;
            found_r <= 1'b0;
            state_r <= S_SCAN;
          end else begin
            idx_r <= idx_r + CW'(1);
          end
        end
        S_SCAN: begin
          if (idx_r == CW'(SLOTS)) begin
            if (found_r) begin
              state_r <= S_FRD;
            end else if (!grp_r) begin
              grp_r <= 1'b1;
              idx_r <= '0;
            end else begin
              state_r <= S_PEND;
            end
          end else begin
            if (cand && (!found_r || hnd_r[sidx] < hnd_r[best_r])) begin
              best_r  <= sidx;
              found_r <= 1'b1;
            end
            idx_r <= idx_r + CW'(1);
          end
        end
        S_FRD: state_r <= S_FWR;
        S_FWR: begin
          out_valid     <= 1'b1;
          out_kind      <= K_FIRED;
          out_handle    <= 16'(hnd_r[best_r]);
          out_overshoot <= over_sat;
          out_last      <= 1'b0;
          pend_r[best_r] <= 1'b0;
          if (!grp_r) valid_r[best_r] <= 1'b0;
          idx_r   <= '0;
          found_r <= 1'b0;
          state_r <= S_SCAN;
        end
        S_PEND: begin
          out_valid     <= 1'b1;
          out_kind      <= K_PASS;
          out_handle    <= '0;
          out_overshoot <= '0;
          out_last      <= !(passes_r + PW'(1) < PW'(MAX_PASSES) &&
                             lag_r >= {8'd0, tick_use_r});
          passes_r      <= passes_r + PW'(1);
          state_r       <= S_ADV;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

@@ sv/fstt_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the timer table.
// Depends on fstt_pkg; bound to fixed_step_timer_table_top.
module fstt_checker
  import fstt_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_op,
  input logic        out_valid,
  input logic [2:0]  out_kind,
  input logic [15:0] out_handle,
  input logic        out_last
);
  // Add and cancel answer in the next cycle with a single final result.
  a_quick: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_op != OP_ADVANCE |=> out_valid && out_last)
    else $error("add/cancel result missing");

  a_fired_nonlast: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == K_FIRED |-> !out_last)
    else $error("fired result marked last");

  a_added_handle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == K_ADDED |-> out_handle != 16'd0)
    else $error("added without handle");

  // More results of the same advance follow, so the block stays busy.
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("non-final result while idle");
endmodule

bind fixed_step_timer_table_top fstt_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_op(in_op),
  .out_valid(out_valid), .out_kind(out_kind), .out_handle(out_handle),
  .out_last(out_last)
);

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// Testbench for fixed_step_timer_table_top: directed table and random traffic,
// every result checked against an in-bench model of the timer table.
// Depends on fstt_pkg and the RTL of the block.
module testbench;
  import fstt_pkg::*;

  localparam int NSLOT = 8;
  localparam int NPASS = 3;
  localparam longint LAG_SAT = (64'd1 << 40) - 1;
  localparam longint REM_HI = (64'd1 << 33) - 1;
  localparam longint REM_LO = -(64'sd1 <<< 33);

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] handle;
    logic [31:0] over;
    logic        last;
  } timer_result_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] elapsed;
    logic [31:0] delay;
    logic [15:0] cancel;
    logic        typed;
    logic [2:0]  kind;
    logic [15:0] handle;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_op = OP_ADVANCE;
  logic [31:0] in_elapsed_time = '0;
  logic [31:0] in_delay = '0;
  logic [15:0] in_cancel_handle = '0;
  logic        out_valid;
  logic [2:0]  out_kind;
  logic [15:0] out_handle;
  logic [31:0] out_overshoot;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  // model of the table
  logic [31:0] tick_len;
  longint      lag;
  logic [15:0] next_hdl;
  logic        sl_valid [NSLOT];
  logic        sl_periodic [NSLOT];
  logic [15:0] sl_handle [NSLOT];
  longint      sl_rem [NSLOT];
  logic [31:0] sl_period [NSLOT];

  timer_result_t timer_results_due[$];
  int errors = 0;

  fixed_step_timer_table_top i_dut (
    .clk, .rst_n, .start, .busy, .in_op, .in_elapsed_time, .in_delay,
    .in_cancel_handle, .out_valid, .out_kind, .out_handle, .out_overshoot,
    .out_last, .cfg_valid, .cfg_ready, .cfg_data
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #3000000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic queue_result(ref timer_result_t q[$], input timer_result_t item);
    q.insert(q.size(), item);
  endtask

  task automatic fire_timers(input logic periodic, ref timer_result_t res[$]);
    logic pend [NSLOT];
    int best;
    longint ov;
    for (int i = 0; i < NSLOT; i++)
      pend[i] = sl_valid[i] && sl_periodic[i] == periodic && sl_rem[i] <= 0;
    forever begin
      best = -1;
      for (int i = 0; i < NSLOT; i++)
        if (pend[i] && (best < 0 || sl_handle[i] < sl_handle[best])) best = i;
      if (best < 0) break;
      pend[best] = 1'b0;
      ov = -sl_rem[best];
      if (ov > 64'hFFFF_FFFF) ov = 64'hFFFF_FFFF;
      queue_result(res, '{K_FIRED, sl_handle[best], ov[31:0], 1'b0});
      if (periodic) begin
        sl_rem[best] = sl_rem[best] + longint'(sl_period[best]);
        if (sl_rem[best] > REM_HI) sl_rem[best] = REM_HI;
      end else begin
        sl_valid[best] = 1'b0;
      end
    end
  endtask

  // Updates the model for one accepted item and queues its results.
  task automatic timer_table_step(input logic [1:0] op, input logic [31:0] el,
                                  input logic [31:0] dl, input logic [15:0] ch,
                                  output timer_result_t first);
    timer_result_t res[$];
    longint tk;
    int passes;
    int fs;
    passes = 0;
    fs = -1;
    if (op == OP_ADVANCE) begin
      tk = (tick_len == 0) ? 1 : longint'(tick_len);
      lag = lag + longint'(el);
      if (lag > LAG_SAT) lag = LAG_SAT;
      while (passes < NPASS && lag >= tk) begin
        for (int i = 0; i < NSLOT; i++)
          if (sl_valid[i]) begin
            sl_rem[i] = sl_rem[i] - tk;
            if (sl_rem[i] < REM_LO) sl_rem[i] = REM_LO;
          end
        fire_timers(1'b0, res);
        fire_timers(1'b1, res);
        queue_result(res, '{K_PASS, 16'd0, 32'd0, 1'b0});
        lag = lag - tk;
        passes++;
      end
      if (passes == 0) queue_result(res, '{K_NOPASS, 16'd0, 32'd0, 1'b0});
    end else if (op == OP_CANCEL) begin
      for (int i = 0; i < NSLOT; i++)
        if (sl_valid[i] && sl_handle[i] == ch) sl_valid[i] = 1'b0;
      queue_result(res, '{K_CANCEL, 16'd0, 32'd0, 1'b0});
    end else begin
      for (int i = NSLOT - 1; i >= 0; i--)
        if (!sl_valid[i]) fs = i;
      if (fs < 0) begin
        queue_result(res, '{K_FULL, 16'd0, 32'd0, 1'b0});
      end else begin
        next_hdl = next_hdl + 16'd1;
        if (next_hdl == 0) next_hdl = 16'd1;
        sl_valid[fs] = 1'b1;
        sl_periodic[fs] = (op == OP_ADD_PER);
        sl_handle[fs] = next_hdl;
        sl_rem[fs] = longint'(dl);
        sl_period[fs] = dl;
        queue_result(res, '{K_ADDED, next_hdl, 32'd0, 1'b0});
      end
    end
    res[res.size() - 1].last = 1'b1;
    first = res[0];
    foreach (res[i]) queue_result(timer_results_due, res[i]);
  endtask

  task automatic send_item(input logic [1:0] op, input logic [31:0] el,
                           input logic [31:0] dl, input logic [15:0] ch,
                           input int gap, output timer_result_t first);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_op <= op;
    in_elapsed_time <= el;
    in_delay <= dl;
    in_cancel_handle <= ch;
    do @(posedge clk); while (busy);
    timer_table_step(op, el, dl, ch, first);
  endtask

  task automatic drain_and_write_tick(input logic [31:0] value);
    start <= 1'b0;
    while (timer_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tick_len = value;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [31:0] pick_time(input int small_max);
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(small_max);
    if (r < 92) return $urandom();
    return 32'hFFFF_FFFF - $urandom_range(3);
  endfunction

  // result checker: the receiver never stalls
  always @(posedge clk) begin
    timer_result_t exp_r;
    if (rst_n && out_valid) begin
      if (timer_results_due.size() == 0) begin
        $display("%0t: unexpected result kind=%0d handle=%0d over=%0d last=%0b",
                 $time, out_kind, out_handle, out_overshoot, out_last);
        errors++;
      end else begin
        exp_r = timer_results_due.pop_front();
        if (out_kind !== exp_r.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, exp_r.kind, out_kind);
          errors++;
        end
        if (out_handle !== exp_r.handle) begin
          $display("%0t: handle expected %0d actual %0d", $time, exp_r.handle, out_handle);
          errors++;
        end
        if (out_overshoot !== exp_r.over) begin
          $display("%0t: overshoot expected %0d actual %0d", $time, exp_r.over,
                   out_overshoot);
          errors++;
        end
        if (out_last !== exp_r.last) begin
          $display("%0t: last expected %0b actual %0b", $time, exp_r.last, out_last);
          errors++;
        end
      end
    end
  end

  initial begin
    stim_row_t rows[$];
    timer_result_t first;
    logic [1:0] op;
    logic [15:0] ch;
    int live[$];
    int r;
    int wait_cnt;

    tick_len = 32'd16;
    lag = 0;
    next_hdl = '0;
    for (int i = 0; i < NSLOT; i++) begin
      sl_valid[i] = 1'b0;
      sl_periodic[i] = 1'b0;
      sl_handle[i] = '0;
      sl_rem[i] = 0;
      sl_period[i] = '0;
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    //        op          elapsed        delay          cancel  typed kind      handle
    rows = '{
      '{OP_ADVANCE, 32'd0,         32'd0,         16'd0,  1'b1, K_NOPASS, 16'd0},
      '{OP_CANCEL,  32'd0,         32'd0,         16'd5,  1'b1, K_CANCEL, 16'd0},
      '{OP_ADD_ONE, 32'd0,         32'd0,         16'd0,  1'b1, K_ADDED,  16'd1},
      '{OP_ADD_PER, 32'd0,         32'd0,         16'd0,  1'b1, K_ADDED,  16'd2},
      '{OP_ADVANCE, 32'd15,        32'd0,         16'd0,  1'b1, K_NOPASS, 16'd0},
      '{OP_ADVANCE, 32'd1,         32'd0,         16'd0,  1'b0, 3'd0,     16'd0},
      '{OP_ADD_ONE, 32'd0,         32'hFFFF_FFFF, 16'd0,  1'b1, K_ADDED,  16'd3},
      '{OP_ADD_PER, 32'd0,         32'hFFFF_FFFF, 16'd0,  1'b1, K_ADDED,  16'd4},
      '{OP_ADD_PER, 32'd0,         32'd40,        16'd0,  1'b1, K_ADDED,  16'd5},
      '{OP_ADD_ONE, 32'd0,         32'd20,        16'd0,  1'b1, K_ADDED,  16'd6},
      '{OP_ADD_ONE, 32'd0,         32'd5,         16'd0,  1'b1, K_ADDED,  16'd7},
      '{OP_ADD_PER, 32'd0,         32'd17,        16'd0,  1'b1, K_ADDED,  16'd8},
      '{OP_ADD_ONE, 32'd0,         32'd100,       16'd0,  1'b0, 3'd0,     16'd0},
      '{OP_ADD_ONE, 32'd0,         32'd1,         16'd0,  1'b1, K_FULL,   16'd0},
      '{OP_ADD_PER, 32'd0,         32'd1,         16'd0,  1'b1, K_FULL,   16'd0},
      '{OP_CANCEL,  32'd0,         32'd0,         16'd9,  1'b1, K_CANCEL, 16'd0},
      '{OP_ADD_ONE, 32'd0,         32'd3,         16'd0,  1'b1, K_ADDED,  16'd10},
      '{OP_ADVANCE, 32'hFFFF_FFFF, 32'd0,         16'd0,  1'b0, 3'd0,     16'd0},
      '{OP_ADVANCE, 32'd0,         32'd0,         16'd0,  1'b0, 3'd0,     16'd0},
      '{OP_CANCEL,  32'd0,         32'd0,         16'hFFFF, 1'b1, K_CANCEL, 16'd0},
      '{OP_CANCEL,  32'd0,         32'd0,         16'd4,  1'b1, K_CANCEL, 16'd0},
      '{OP_ADVANCE, 32'd48,        32'd0,         16'd0,  1'b0, 3'd0,     16'd0}
    };
    foreach (rows[i]) begin
      send_item(rows[i].op, rows[i].elapsed, rows[i].delay, rows[i].cancel,
                pick_gap(), first);
      if (rows[i].typed && (first.kind !== rows[i].kind ||
                            first.handle !== rows[i].handle)) begin
        $display("%0t: row %0d expected kind %0d handle %0d, model gives %0d %0d",
                 $time, i, rows[i].kind, rows[i].handle, first.kind, first.handle);
        errors++;
      end
    end

    // Zero tick behaves as one; the largest tick needs the lag to reach it.
    drain_and_write_tick(32'd0);
    send_item(OP_ADVANCE, 32'd2, 32'd0, 16'd0, 0, first);
    send_item(OP_ADVANCE, 32'd5, 32'd0, 16'd0, 0, first);
    drain_and_write_tick(32'hFFFF_FFFF);
    send_item(OP_ADVANCE, 32'hFFFF_FFFF, 32'd0, 16'd0, 0, first);
    send_item(OP_ADVANCE, 32'hFFFF_FFFF, 32'd0, 16'd0, 0, first);
    drain_and_write_tick(32'd1);

    // Free the table, then park a few long timers on low slots.
    for (int i = 0; i < NSLOT; i++)
      if (sl_valid[i]) send_item(OP_CANCEL, 32'd0, 32'd0, sl_handle[i], 0, first);
    for (int i = 0; i < 3; i++)
      send_item(i[0] ? OP_ADD_PER : OP_ADD_ONE, 32'd0, 32'd200 + i, 16'd0, 0, first);

    // random traffic, tick changed between phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: drain_and_write_tick(32'd1);
        1: drain_and_write_tick(32'd7);
        2: drain_and_write_tick($urandom());
        default: drain_and_write_tick(32'd16);
      endcase
      for (int n = 0; n < 32; n++) begin
        r = $urandom_range(99);
        if (r < 40) op = OP_ADVANCE;
        else if (r < 60) op = OP_ADD_ONE;
        else if (r < 78) op = OP_ADD_PER;
        else op = OP_CANCEL;
        live.delete();
        for (int i = 0; i < NSLOT; i++)
          if (sl_valid[i]) live = {live, i};
        ch = 16'($urandom());
        if (live.size() != 0 && $urandom_range(3) != 0)
          ch = sl_handle[live[$urandom_range(live.size() - 1)]];
        send_item(op, (ph == 2) ? $urandom() : pick_time(40), pick_time(60), ch,
                  pick_gap(), first);
      end
    end

    start <= 1'b0;
    wait_cnt = 0;
    while (timer_results_due.size() != 0 && wait_cnt < 20000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (400) @(posedge clk);
    if (errors == 0 && timer_results_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
